// ----- rtl/core/basic_comment_stripper_top_assert.svh -----
// Assertion macros for the BASIC comment stripper.
`ifndef BASIC_COMMENT_STRIPPER_TOP_ASSERT_SVH
`define BASIC_COMMENT_STRIPPER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Checks a property on every clock edge outside reset.
`define BCS_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("bcs assertion failed");
// Checks that a condition in one cycle leads to a consequence in the next.
`define BCS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("bcs assertion failed");
`else
`define BCS_ASSERT(name, prop)
`define BCS_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ----- rtl/core/bcs_pkg.sv -----
// Types, character constants and helpers for the BASIC comment stripper.
package bcs_pkg;

    // Characters the filter recognizes.
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;

    // Input command codes.
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_EOL  = 1'b1;

    // Result queue geometry.
    localparam int          QDEPTH    = 8;
    localparam int          QAW       = 3;
    localparam int          MAXRES    = 4;
    localparam logic [3:0]  ACCEPT_MAX = 4'd4;

    // One result word.
    typedef struct packed {
        logic [7:0] out_char;
        logic       end_mark;
        logic       last;
    } t_result;

    // ASCII alphanumeric test: digits and both letter cases only.
    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    // Character held at a given place of the REM candidate.
    function automatic logic [7:0] held_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = CH_R;
            2'd1:    c = CH_E;
            default: c = CH_M;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/basic_comment_stripper_top.sv -----
// Top level of the BASIC comment stripper: line state and result queue.
// The stripper takes one word per cycle while o_stall is low: a character or
// an end-of-line marker. Each accepted word is decoded against the line state
// in the same cycle and yields zero to four result words (held R, RE or REM
// characters flushed ahead of the current one, or an end marker), which enter
// an eight-entry result queue and appear on the output one per cycle while
// i_stall is low. Input is taken in every cycle in which the queue holds four
// words or fewer, so the sustained rate is one word per cycle; a word that
// flushes held characters adds up to three extra output words, which the queue
// absorbs and which stall the input only when the downstream side also stalls.
module basic_comment_stripper_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_cmd,
    input  logic [7:0] i_ch,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_end_mark,
    output logic       o_last
);
    import bcs_pkg::*;

    `include "basic_comment_stripper_top_assert.svh"

    // Line state.
    logic       r_in_quote, n_in_quote;
    logic       r_prev_alnum, n_prev_alnum;
    logic [1:0] r_held, n_held;
    logic       r_discard, n_discard;

    // Result queue.
    t_result          r_queue [QDEPTH];
    logic [QAW-1:0]   r_wr, n_wr;
    logic [QAW-1:0]   r_rd, n_rd;
    logic [QAW:0]     r_count, n_count;

    // Results produced by the current word.
    t_result          res [MAXRES];
    logic [2:0]       nres;

    logic in_acc;
    logic pop;

    assign o_stall = (r_count > ACCEPT_MAX);
    assign in_acc  = i_valid && !o_stall;
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;

    assign o_out_char = r_queue[r_rd].out_char;
    assign o_end_mark = r_queue[r_rd].end_mark;
    assign o_last     = r_queue[r_rd].last;

    // Decode one word against the line state.
    always_comb begin
        logic [2:0] fc;
        logic       prev_eff;
        logic       put_char;
        n_in_quote   = r_in_quote;
        n_prev_alnum = r_prev_alnum;
        n_held       = r_held;
        n_discard    = r_discard;
        nres         = '0;
        fc           = '0;
        prev_eff     = r_prev_alnum;
        put_char     = 1'b0;
        for (int i = 0; i < MAXRES; i++) begin
            res[i] = '0;
        end
        if (in_acc) begin
            if (i_cmd == CMD_EOL) begin
                // A complete REM at line end is a comment; shorter candidates flush.
                fc = (r_held == 2'd3) ? 3'd0 : {1'b0, r_held};
                for (int i = 0; i < 3; i++) begin
                    if (3'(i) < fc) begin
                        res[i] = '{out_char: held_char(2'(i)), end_mark: 1'b0, last: 1'b0};
                    end
                end
                res[fc[1:0]] = '{out_char: 8'h00, end_mark: 1'b1, last: 1'b0};
                nres         = fc + 3'd1;
                n_in_quote   = 1'b0;
                n_prev_alnum = 1'b0;
                n_held       = '0;
                n_discard    = 1'b0;
            end else if (r_discard) begin
                nres = '0;
            end else if (r_held == 2'd1 && i_ch == CH_E) begin
                n_held       = 2'd2;
                n_prev_alnum = 1'b1;
            end else if (r_held == 2'd2 && i_ch == CH_M) begin
                n_held       = 2'd3;
                n_prev_alnum = 1'b1;
            end else if (r_held == 2'd3 && !is_alnum(i_ch)) begin
                n_held    = '0;
                n_discard = 1'b1;
            end else begin
                // Failed candidate: flush held characters, then handle this one.
                fc = {1'b0, r_held};
                if (r_held != '0) begin
                    prev_eff = 1'b1;
                end
                n_held = '0;
                if (i_ch == CH_QUOTE) begin
                    n_in_quote = !r_in_quote;
                    put_char   = 1'b1;
                end else if (!r_in_quote && i_ch == CH_APOS) begin
                    n_discard = 1'b1;
                end else if (!r_in_quote && i_ch == CH_R && !prev_eff) begin
                    n_held = 2'd1;
                end else begin
                    put_char = 1'b1;
                end
                n_prev_alnum = is_alnum(i_ch);
                for (int i = 0; i < MAXRES; i++) begin
                    if (3'(i) < fc) begin
                        res[i] = '{out_char: held_char(2'(i)), end_mark: 1'b0, last: 1'b0};
                    end else if (3'(i) == fc && put_char) begin
                        res[i] = '{out_char: i_ch, end_mark: 1'b0, last: 1'b0};
                    end
                end
                nres = fc + {2'b0, put_char};
            end
        end
        // Mark the final result of this word.
        if (nres != '0) begin
            res[2'(nres - 3'd1)].last = 1'b1;
        end
    end

    // Queue pointer and count updates.
    always_comb begin
        n_wr    = r_wr + QAW'(nres);
        n_rd    = r_rd + QAW'(pop);
        n_count = r_count + (QAW+1)'(nres) - (QAW+1)'(pop);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quote   <= 1'b0;
            r_prev_alnum <= 1'b0;
            r_held       <= '0;
            r_discard    <= 1'b0;
            r_wr         <= '0;
            r_rd         <= '0;
            r_count      <= '0;
        end else begin
            r_in_quote   <= n_in_quote;
            r_prev_alnum <= n_prev_alnum;
            r_held       <= n_held;
            r_discard    <= n_discard;
            r_wr         <= n_wr;
            r_rd         <= n_rd;
            r_count      <= n_count;
        end
    end

    // Queue storage writes.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAXRES; k++) begin
            if (3'(k) < nres) begin
                r_queue[r_wr + QAW'(k)] <= res[k];
            end
        end
    end

    // A held candidate never coexists with discarding or quoting.
    `BCS_ASSERT(a_held_not_discard, (r_held != '0) |-> (!r_discard && !r_in_quote))
    // Held characters are letters, so the previous character counts as alphanumeric.
    `BCS_ASSERT(a_held_prev_alnum, (r_held != '0) |-> r_prev_alnum)
    // The queue never exceeds its depth.
    `BCS_ASSERT(a_queue_bound, r_count <= (QAW+1)'(QDEPTH))
    // An end of line returns the line state to its start.
    `BCS_ASSERT_NEXT(a_eol_clears, in_acc && i_cmd == CMD_EOL,
        r_held == '0 && !r_in_quote && !r_discard && !r_prev_alnum && o_valid)

endmodule
